[rtl/vrt_pkg.sv]
`default_nettype none

package vrt_pkg;

   // field widths fixed by the stream format
   localparam int ORG_W      = 32;
   localparam int DIR_W      = 16;
   localparam int CELL_OUT_W = 16;
   localparam int AXIS_W     = 2;
   localparam int T_W        = 32;
   localparam int REQ_DATA_W = 3 * ORG_W + 3 * DIR_W;
   localparam int RSP_DATA_W = 3 * CELL_OUT_W;

   // "large" ray distance, also the saturation point of every sum
   localparam logic [T_W-1:0] T_LARGE = '1;

   // request kinds carried in req_tuser
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   // moved-axis codes carried in rsp_tuser
   localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd3;

   // per-axis step direction
   localparam logic [1:0] SIGN_ZERO = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd3;

   // axis index into the per-axis state (0..2)
   localparam logic [1:0] IDX_X = 2'd0;
   localparam logic [1:0] IDX_Y = 2'd1;
   localparam logic [1:0] IDX_Z = 2'd2;

endpackage

`default_nettype wire

[rtl/voxel_ray_traversal.sv]
// Step word: accepted in idle, then passes the pick, update and result states in that order; the
//   result state holds while the output register is full, and the next word is taken back in idle.
// Load word: six divisions (tMax and tDelta per axis) on one shared restoring divider,
//   QW quotient bits each with QW = max(FRAC_BITS + 16, 33); zero direction components skip
//   theirs. A result waiting in the output register holds the next.
// Synchronous reset: cells zero, step signs zero, tMax and tDelta all ones, no result.
`default_nettype none

module voxel_ray_traversal #(
   parameter int FRAC_BITS = 16,
   parameter int CELL_BITS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   // request: tdata = origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest first)
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [vrt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request: tuser = func
   input  wire                                req_tuser,
   // result: tdata = cell_x, cell_y, cell_z (lowest first)
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [vrt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // result: tuser = moved_axis
   output logic [vrt_pkg::AXIS_W-1:0]         rsp_tuser
);

   localparam int QW    = (FRAC_BITS + 16 > vrt_pkg::T_W + 1) ? FRAC_BITS + 16
                                                               : vrt_pkg::T_W + 1;
   localparam int CNT_W = $clog2(QW);
   localparam logic [2:0] JOB_LAST = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_SETUP,
      ST_DIV_RUN,
      ST_PICK,
      ST_APPLY,
      ST_RESULT
   } state_type;

   state_type                       state_ff;
   logic [2:0]                      job_ff;
   logic [CNT_W-1:0]                cnt_ff;
   logic [1:0]                      sel_ff;
   logic [vrt_pkg::AXIS_W-1:0]      axis_ff;
   logic                            rsp_valid_ff;
   logic [vrt_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic [vrt_pkg::AXIS_W-1:0]      rsp_axis_ff;

   // ray state
   logic [CELL_BITS-1:0]            cell_ff   [3];
   logic [1:0]                      sign_ff   [3];
   logic [vrt_pkg::T_W-1:0]         t_bnd_ff  [3];
   logic [vrt_pkg::T_W-1:0]         t_cell_ff [3];
   logic [FRAC_BITS-1:0]            frac_ff   [3];
   logic [vrt_pkg::DIR_W-1:0]       mag_ax_ff [3];

   // shared divider
   logic [QW-1:0]                   div_num_ff;
   logic [vrt_pkg::DIR_W-1:0]       div_rem_ff;
   logic [vrt_pkg::DIR_W-1:0]       div_mag_ff;
   logic [QW-1:0]                   div_num_in;
   logic [vrt_pkg::DIR_W-1:0]       div_rem_in;
   logic [vrt_pkg::T_W-1:0]         div_quot;

   logic                            req_fire;
   logic                            rsp_free;
   logic [1:0]                      job_axis;
   logic                            job_is_cell;
   logic [FRAC_BITS:0]              bnd_span;
   logic [QW-1:0]                   num_setup;
   logic [1:0]                      pick;
   logic [vrt_pkg::T_W:0]           tsum;
   logic [vrt_pkg::T_W-1:0]         tsum_sat;

   logic signed [vrt_pkg::ORG_W-1:0] org_in [3];
   logic [vrt_pkg::DIR_W-1:0]        dir_in [3];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_axis_ff;

   // unpack request word
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         org_in[k] = req_tdata[k*vrt_pkg::ORG_W +: vrt_pkg::ORG_W];
         dir_in[k] = req_tdata[3*vrt_pkg::ORG_W + k*vrt_pkg::DIR_W +: vrt_pkg::DIR_W];
      end
   end

   // form numerator for the current division job
   assign job_axis    = job_ff[2:1];
   assign job_is_cell = job_ff[0];

   always_comb begin
      if (sign_ff[job_axis] == vrt_pkg::SIGN_NEG) begin
         bnd_span = {1'b0, frac_ff[job_axis]};
      end else begin
         bnd_span = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_ff[job_axis]};
      end
      if (job_is_cell) begin
         num_setup = QW'({1'b1, {(FRAC_BITS + 15){1'b0}}});
      end else begin
         num_setup = QW'({bnd_span, 15'b0});
      end
   end

   // one restoring division step, saturate quotient to 32 bits
   always_comb begin
      logic [vrt_pkg::DIR_W:0]   rem_sh;
      logic [vrt_pkg::DIR_W+1:0] diff;
      rem_sh     = {div_rem_ff, div_num_ff[QW-1]};
      diff       = {1'b0, rem_sh} - {2'b00, div_mag_ff};
      div_rem_in = diff[vrt_pkg::DIR_W+1] ? rem_sh[vrt_pkg::DIR_W-1:0]
                                          : diff[vrt_pkg::DIR_W-1:0];
      div_num_in = {div_num_ff[QW-2:0], ~diff[vrt_pkg::DIR_W+1]};
      div_quot   = (|div_num_in[QW-1:vrt_pkg::T_W]) ? vrt_pkg::T_LARGE
                                                    : div_num_in[vrt_pkg::T_W-1:0];
   end

   // pick axis with smallest tMax, ties to Z, then Y
   always_comb begin
      if (t_bnd_ff[vrt_pkg::IDX_X] < t_bnd_ff[vrt_pkg::IDX_Y] &&
          t_bnd_ff[vrt_pkg::IDX_X] < t_bnd_ff[vrt_pkg::IDX_Z]) begin
         pick = vrt_pkg::IDX_X;
      end else if (t_bnd_ff[vrt_pkg::IDX_Y] < t_bnd_ff[vrt_pkg::IDX_Z]) begin
         pick = vrt_pkg::IDX_Y;
      end else begin
         pick = vrt_pkg::IDX_Z;
      end
   end

   // saturating tMax + tDelta on the chosen axis
   assign tsum     = {1'b0, t_bnd_ff[sel_ff]} + {1'b0, t_cell_ff[sel_ff]};
   assign tsum_sat = (tsum[vrt_pkg::T_W] | (&tsum[vrt_pkg::T_W-1:0])) ? vrt_pkg::T_LARGE
                                                                       : tsum[vrt_pkg::T_W-1:0];

   // sequencer, ray state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            cell_ff[k]   <= '0;
            sign_ff[k]   <= vrt_pkg::SIGN_ZERO;
            t_bnd_ff[k]  <= vrt_pkg::T_LARGE;
            t_cell_ff[k] <= vrt_pkg::T_LARGE;
         end
      end else begin
         // drop taken result unless a new one is loaded in its place
         if (rsp_valid_ff && rsp_tready && state_ff != ST_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_tuser == vrt_pkg::FUNC_LOAD) begin
                     // latch start cell, sign, fraction and magnitude per axis
                     for (int k = 0; k < 3; k++) begin
                        cell_ff[k] <= CELL_BITS'(org_in[k] >>> FRAC_BITS);
                        frac_ff[k] <= org_in[k][FRAC_BITS-1:0];
                        if (dir_in[k] == '0) begin
                           sign_ff[k] <= vrt_pkg::SIGN_ZERO;
                        end else if (dir_in[k][vrt_pkg::DIR_W-1]) begin
                           sign_ff[k] <= vrt_pkg::SIGN_NEG;
                        end else begin
                           sign_ff[k] <= vrt_pkg::SIGN_POS;
                        end
                        mag_ax_ff[k] <= dir_in[k][vrt_pkg::DIR_W-1] ? (~dir_in[k] + 1'b1)
                                                                    : dir_in[k];
                     end
                     axis_ff  <= vrt_pkg::AXIS_NONE;
                     job_ff   <= '0;
                     state_ff <= ST_DIV_SETUP;
                  end else begin
                     state_ff <= ST_PICK;
                  end
               end
            end
            ST_DIV_SETUP: begin
               if (sign_ff[job_axis] == vrt_pkg::SIGN_ZERO) begin
                  // zero direction: large distance, no division
                  if (job_is_cell) begin
                     t_cell_ff[job_axis] <= vrt_pkg::T_LARGE;
                  end else begin
                     t_bnd_ff[job_axis] <= vrt_pkg::T_LARGE;
                  end
                  if (job_ff == JOB_LAST) begin
                     state_ff <= ST_RESULT;
                  end else begin
                     job_ff <= job_ff + 3'd1;
                  end
               end else begin
                  div_num_ff <= num_setup;
                  div_rem_ff <= '0;
                  div_mag_ff <= mag_ax_ff[job_axis];
                  cnt_ff     <= '0;
                  state_ff   <= ST_DIV_RUN;
               end
            end
            ST_DIV_RUN: begin
               div_num_ff <= div_num_in;
               div_rem_ff <= div_rem_in;
               cnt_ff     <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(QW - 1)) begin
                  if (job_is_cell) begin
                     t_cell_ff[job_axis] <= div_quot;
                  end else begin
                     t_bnd_ff[job_axis] <= div_quot;
                  end
                  if (job_ff == JOB_LAST) begin
                     state_ff <= ST_RESULT;
                  end else begin
                     job_ff   <= job_ff + 3'd1;
                     state_ff <= ST_DIV_SETUP;
                  end
               end
            end
            ST_PICK: begin
               sel_ff   <= pick;
               axis_ff  <= pick + 2'd1;
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               // advance cell along chosen axis, wrap in CELL_BITS
               if (sign_ff[sel_ff] == vrt_pkg::SIGN_POS) begin
                  cell_ff[sel_ff] <= cell_ff[sel_ff] + 1'b1;
               end else if (sign_ff[sel_ff] == vrt_pkg::SIGN_NEG) begin
                  cell_ff[sel_ff] <= cell_ff[sel_ff] - 1'b1;
               end
               t_bnd_ff[sel_ff] <= tsum_sat;
               state_ff         <= ST_RESULT;
            end
            ST_RESULT: begin
               // hold until output register is free
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {vrt_pkg::CELL_OUT_W'(cell_ff[vrt_pkg::IDX_Z]),
                                   vrt_pkg::CELL_OUT_W'(cell_ff[vrt_pkg::IDX_Y]),
                                   vrt_pkg::CELL_OUT_W'(cell_ff[vrt_pkg::IDX_X])};
                  rsp_axis_ff  <= axis_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // divider remainder stays below the divisor throughout a division
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN) |-> (div_rem_ff < div_mag_ff))
      else $error("divider remainder not below divisor");

   // an accepted word blocks the next one in the cycle after
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted while a word is in work");

   // a result appears only from the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result raised outside the result state");

endmodule

`default_nettype wire
